FILE: rtl/permuted_sorted_node_table_defines.svh
// assertion macros shared by the node table rtl
// expects clk and rst in scope at the point of use
`ifndef PERMUTED_SORTED_NODE_TABLE_DEFINES_SVH
`define PERMUTED_SORTED_NODE_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pst_pkg.sv
// shared types and constants for the permuted sorted node table
// no dependencies
package pst_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int CNT_W = 5;
  localparam int KIND_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UPSERT = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // outcome of the shared key comparator
  typedef struct packed {
    logic ge;
    logic eq;
  } cmp_res_t;

endpackage

FILE: rtl/pst_ifs.sv
// request and response channel interfaces for the node table
// depends on pst_pkg
interface pst_req_if;
  logic valid;
  logic ready;
  logic [pst_pkg::KIND_W-1:0] kind;
  logic [pst_pkg::KEY_W-1:0] key;
  logic [pst_pkg::VAL_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink (input valid, kind, key, value, output ready);
endinterface

interface pst_rsp_if;
  logic valid;
  logic ready;
  logic [pst_pkg::STATUS_W-1:0] status;
  logic found;
  logic [pst_pkg::VAL_W-1:0] value_out;
  logic [pst_pkg::CNT_W-1:0] rank;
  logic [pst_pkg::CNT_W-1:0] count;

  modport source (output valid, status, found, value_out, rank, count, input ready);
  modport sink (input valid, status, found, value_out, rank, count, output ready);
endinterface

FILE: rtl/pst_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pst_cmp.sv
// shared unsigned key comparator used by every scan step
// depends on pst_pkg
module pst_cmp (
  input  logic [pst_pkg::KEY_W-1:0] stored,
  input  logic [pst_pkg::KEY_W-1:0] probe,
  output pst_pkg::cmp_res_t         res
);

  always_comb begin
    res.ge = (stored >= probe);
    res.eq = (stored == probe);
  end

endmodule

FILE: rtl/permuted_sorted_node_table.sv
// channel  dir  payload                                  taken when
// req      in   kind, key, value                         req.valid && req.ready
// rsp      out  status, found, value_out, rank, count    rsp.valid && rsp.ready
//
// steps per request: accept, scan of sorted positions up to the first key not below the probe,
//   decide, a value read on a lookup hit, a read and a write per slot moved down on remove,
//   load of the result; worst case is a remove of the last sorted position in physical slot 0
// the scan walks sorted positions through the single key ram read port, one per cycle
// remove compaction moves each slot with a read step and then a write step through the same ram ports
// the load step waits while the output register holds a result not yet taken
// synchronous reset empties the node at once (order vector and count cleared)
// a new request is taken while a result still waits in the output register
// depends on pst_pkg, pst_ifs, pst_ram, pst_cmp and the defines header
`include "permuted_sorted_node_table_defines.svh"

module permuted_sorted_node_table #(
  parameter int CAPACITY = pst_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pst_req_if.sink   req,
  pst_rsp_if.source rsp
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W = pst_pkg::CNT_W;
  localparam int KEY_W = pst_pkg::KEY_W;
  localparam int VAL_W = pst_pkg::VAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_VREAD = 3'd3;
  localparam logic [2:0] S_SH_RD = 3'd4;
  localparam logic [2:0] S_SH_WR = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  // control state
  logic [2:0] state;
  logic [CNT_W-1:0] entry_count;
  logic [SLOT_W-1:0] order [CAPACITY];
  logic res_valid;

  // working registers for the request in flight
  logic [pst_pkg::KIND_W-1:0] kind_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [CNT_W-1:0] pos;
  logic hit;
  logic [VAL_W-1:0] vout;
  logic [pst_pkg::STATUS_W-1:0] st_r;
  logic [SLOT_W-1:0] shift_idx;

  // output register
  logic [pst_pkg::STATUS_W-1:0] res_status;
  logic res_found;
  logic [VAL_W-1:0] res_value;
  logic [CNT_W-1:0] res_rank;
  logic [CNT_W-1:0] res_count;

  // ram ports
  logic [SLOT_W-1:0] raddr;
  logic key_we, val_we;
  logic [SLOT_W-1:0] key_waddr, val_waddr;
  logic [KEY_W-1:0] key_wdata, key_rdata;
  logic [VAL_W-1:0] val_wdata, val_rdata;

  pst_pkg::cmp_res_t cmp;

  logic req_fire, rsp_fire, res_load;
  logic [CNT_W-1:0] pos_inc;
  logic [SLOT_W-1:0] pos_slot, hit_slot;
  logic full;
  logic do_insert, do_remove, do_vwrite, do_vread;
  logic [SLOT_W-1:0] ins_order [CAPACITY];
  logic [SLOT_W-1:0] rem_order [CAPACITY];
  logic [CNT_W-1:0] new_count_rem;

  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign res_load = (state == S_FINISH) && (!res_valid || rsp.ready);

  assign pos_inc = pos + CNT_W'(1);
  assign pos_slot = pos[SLOT_W-1:0];
  assign hit_slot = order[pos_slot];
  assign full = (entry_count >= CNT_W'(CAPACITY));
  assign new_count_rem = entry_count - CNT_W'(1);

  // what the decide step does with the scan outcome
  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    do_vwrite = 1'b0;
    do_vread = 1'b0;
    if (state == S_DECIDE) begin
      unique case (kind_r)
        pst_pkg::KIND_LOOKUP: do_vread = hit;
        pst_pkg::KIND_INSERT: do_insert = !hit && !full;
        pst_pkg::KIND_REMOVE: do_remove = hit;
        pst_pkg::KIND_UPSERT: begin
          do_vwrite = hit;
          do_insert = !hit && !full;
        end
        default: ;
      endcase
    end
  end

  // shared comparator: stored key at the current sorted position against the probe
  pst_cmp u_cmp (
    .stored (key_rdata),
    .probe  (key_r),
    .res    (cmp)
  );

  // one read address serves both rams: scan, value fetch or compaction source
  always_comb begin
    raddr = order[0];
    case (state)
      S_SCAN:   raddr = order[pos_inc[SLOT_W-1:0]];
      S_DECIDE: raddr = hit_slot;
      S_SH_RD:  raddr = shift_idx + SLOT_W'(1);
      default:  raddr = order[0];
    endcase
  end

  // new entry goes to the first free physical slot
  always_comb begin
    key_we = do_insert || (state == S_SH_WR);
    key_waddr = (state == S_SH_WR) ? shift_idx : entry_count[SLOT_W-1:0];
    key_wdata = (state == S_SH_WR) ? key_rdata : key_r;
    val_we = do_insert || do_vwrite || (state == S_SH_WR);
    val_waddr = (state == S_SH_WR) ? shift_idx :
                do_vwrite ? hit_slot : entry_count[SLOT_W-1:0];
    val_wdata = (state == S_SH_WR) ? val_rdata : val_r;
  end

  pst_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  pst_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  // order vector with the new slot opened at the scan position
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) < pos) begin
        ins_order[i] = order[i];
      end else if (CNT_W'(i) == pos) begin
        ins_order[i] = entry_count[SLOT_W-1:0];
      end else begin
        ins_order[i] = order[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // order vector with the hit position closed and slots above it renumbered
  always_comb begin
    logic [SLOT_W-1:0] src;
    for (int i = 0; i < CAPACITY; i++) begin
      src = (CNT_W'(i) < pos) ? order[i] : order[(i + 1 < CAPACITY) ? i + 1 : i];
      if (CNT_W'(i) < new_count_rem) begin
        rem_order[i] = (src > hit_slot) ? src - SLOT_W'(1) : src;
      end else begin
        rem_order[i] = '0;
      end
    end
  end

  // sequencer and node state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      entry_count <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        order[i] <= '0;
      end
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (rsp_fire) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            // empty node: nothing to scan
            state <= (entry_count == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (cmp.ge || pos_inc == entry_count) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (do_insert) begin
            entry_count <= entry_count + CNT_W'(1);
            for (int i = 0; i < CAPACITY; i++) begin
              order[i] <= ins_order[i];
            end
            state <= S_FINISH;
          end else if (do_remove) begin
            entry_count <= new_count_rem;
            for (int i = 0; i < CAPACITY; i++) begin
              order[i] <= rem_order[i];
            end
            // compaction only when a later physical slot exists
            state <= ((CNT_W'(hit_slot) + CNT_W'(1)) < entry_count) ? S_SH_RD : S_FINISH;
          end else if (do_vread) begin
            state <= S_VREAD;
          end else begin
            state <= S_FINISH;
          end
        end
        S_VREAD: state <= S_FINISH;
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          state <= ((CNT_W'(shift_idx) + CNT_W'(1)) < entry_count) ? S_SH_RD : S_FINISH;
        end
        S_FINISH: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          kind_r <= req.kind;
          key_r <= req.key;
          val_r <= req.value;
          pos <= '0;
          hit <= 1'b0;
          vout <= '0;
        end
      end
      S_SCAN: begin
        if (cmp.ge) begin
          hit <= cmp.eq;
        end else begin
          pos <= pos_inc;
        end
      end
      S_DECIDE: begin
        case (kind_r) inside
          pst_pkg::KIND_LOOKUP, pst_pkg::KIND_REMOVE: begin
            st_r <= hit ? pst_pkg::ST_DONE : pst_pkg::ST_ABSENT;
          end
          pst_pkg::KIND_INSERT: begin
            if (hit) st_r <= pst_pkg::ST_DUP;
            else if (full) st_r <= pst_pkg::ST_FULL;
            else st_r <= pst_pkg::ST_DONE;
          end
          default: begin
            st_r <= (!hit && full) ? pst_pkg::ST_FULL : pst_pkg::ST_DONE;
          end
        endcase
        shift_idx <= hit_slot;
      end
      S_VREAD: vout <= val_rdata;
      S_SH_WR: shift_idx <= shift_idx + SLOT_W'(1);
      default: ;
    endcase
    if (res_load) begin
      res_status <= st_r;
      res_found <= hit;
      res_value <= vout;
      res_rank <= pos;
      res_count <= entry_count;
    end
  end

  assign rsp.valid = res_valid;
  assign rsp.status = res_status;
  assign rsp.found = res_found;
  assign rsp.value_out = res_value;
  assign rsp.rank = res_rank;
  assign rsp.count = res_count;

  `PST_ASSERT_NOW(a_count_cap, 1'b1, entry_count <= CNT_W'(CAPACITY), "entry count above capacity")
  `PST_ASSERT_NOW(a_scan_pos, state == S_SCAN, pos < entry_count, "scan ran past the held entries")
  `PST_ASSERT_NEXT(a_busy_after_req, req_fire, state != S_IDLE, "request taken but sequencer idle")
  `PST_ASSERT_NEXT(a_insert_grows, do_insert, entry_count == $past(entry_count) + CNT_W'(1), "insert did not grow the node")
  `PST_ASSERT_NEXT(a_remove_shrinks, do_remove, entry_count == $past(entry_count) - CNT_W'(1), "remove did not shrink the node")

endmodule

FILE: tb/sv/pst_node_table_check.sv
// observer for the node table: predicts every response from the requests it sees
// depends on pst_pkg and the pst_req_if / pst_rsp_if interfaces
module pst_node_table_check #(
  parameter int CAPACITY = pst_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pst_req_if        req,
  pst_rsp_if        rsp,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [VAL_W-1:0]    value_out;
    logic [CNT_W-1:0]    rank;
    logic [CNT_W-1:0]    count;
  } node_result_t;

  // shadow copy of the node
  logic [KEY_W-1:0] key_mem [CAPACITY_DEF];
  logic [VAL_W-1:0] val_mem [CAPACITY_DEF];
  logic [3:0]       sorted_slot [CAPACITY_DEF];
  int unsigned      held;

  node_result_t pending_results [$];
  int           err_count;
  int           pending_n;

  assign mismatches  = err_count;
  assign outstanding = pending_n;

  // new entry goes to the next free physical slot, order vector opens a gap at pos
  function automatic void store_entry(input int unsigned pos, input logic [KEY_W-1:0] k,
                                      input logic [VAL_W-1:0] v);
    key_mem[held] = k;
    val_mem[held] = v;
    for (int unsigned i = held; i > pos; i--) sorted_slot[i] = sorted_slot[i-1];
    sorted_slot[pos] = 4'(held);
    held++;
  endfunction

  function automatic node_result_t node_op_outcome(input logic [KIND_W-1:0] op,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [VAL_W-1:0] v);
    node_result_t r;
    int unsigned  pos;
    int unsigned  phys;
    logic         hit;
    logic         full;
    r = '0;
    r.status = ST_DONE;
    hit = 1'b0;
    pos = held;
    // first sorted position whose key is not below k
    for (int unsigned i = 0; i < held; i++) begin
      if (key_mem[sorted_slot[i]] >= k) begin
        pos = i;
        hit = (key_mem[sorted_slot[i]] == k);
        break;
      end
    end
    full = (held >= CAPACITY);
    case (op)
      KIND_LOOKUP: begin
        if (hit) r.value_out = val_mem[sorted_slot[pos]];
        else r.status = ST_ABSENT;
      end
      KIND_INSERT: begin
        if (hit) r.status = ST_DUP;
        else if (full) r.status = ST_FULL;
        else store_entry(pos, k, v);
      end
      KIND_REMOVE: begin
        if (hit) begin
          // compact physical slots, then drop the position and renumber
          phys = sorted_slot[pos];
          for (int unsigned i = phys; i + 1 < held; i++) begin
            key_mem[i] = key_mem[i+1];
            val_mem[i] = val_mem[i+1];
          end
          for (int unsigned i = pos; i + 1 < held; i++) sorted_slot[i] = sorted_slot[i+1];
          sorted_slot[held-1] = '0;
          held--;
          for (int unsigned i = 0; i < held; i++) begin
            if (sorted_slot[i] > phys) sorted_slot[i]--;
          end
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        if (hit) val_mem[sorted_slot[pos]] = v;
        else if (full) r.status = ST_FULL;
        else store_entry(pos, k, v);
      end
    endcase
    r.found = hit;
    r.rank  = CNT_W'(pos);
    r.count = CNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    node_result_t want;
    if (rst) begin
      held = 0;
      foreach (sorted_slot[i]) sorted_slot[i] = '0;
      pending_results.delete();
      pending_n = 0;
      err_count = 0;
    end else begin
      if (req.valid && req.ready)
        pending_results.push_back(node_op_outcome(req.kind, req.key, req.value));
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          if (err_count < 10)
            $display("[%0t] response with no request waiting: status %0d rank %0d count %0d",
                     $time, rsp.status, rsp.rank, rsp.count);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status || rsp.found !== want.found ||
              rsp.value_out !== want.value_out || rsp.rank !== want.rank ||
              rsp.count !== want.count) begin
            if (err_count < 10)
              $display({"[%0t] response mismatch\n",
                        "  expected status %0d found %0d value %h rank %0d count %0d\n",
                        "  actual   status %0d found %0d value %h rank %0d count %0d"},
                       $time, want.status, want.found, want.value_out, want.rank,
                       want.count, rsp.status, rsp.found, rsp.value_out, rsp.rank,
                       rsp.count);
            err_count++;
          end
        end
      end
      pending_n = pending_results.size();
    end
  end

endmodule

FILE: tb/sv/tb_permuted_sorted_node_table.sv
// top of the node table testbench: clock, reset, request and response traffic, verdict
// depends on pst_pkg, pst_ifs, the node table rtl and pst_node_table_check
module tb_permuted_sorted_node_table;
  timeunit 1ns;
  timeprecision 1ps;

  import pst_pkg::*;

  localparam int ITEMS       = 1600;
  localparam int QUIET_TAIL  = 150;   // last requests run with no idling at all
  localparam int ROUND_LEN   = 160;
  localparam int POOL_SIZE   = 24;    // more keys than the node can hold
  localparam int LONG_HOLD   = 400;   // length of the one response-side hold-off
  localparam int HOLD_AT     = 300;
  localparam int STALL_LIMIT = 3000;  // handshake-free stretch after which the watchdog gives up
  localparam int DRAIN_WAIT  = 60;

  localparam logic [KEY_W-1:0] KEY_TOP = '1;
  localparam logic [KEY_W-1:0] KEY_MSB = 64'h8000_0000_0000_0000;
  localparam logic [KEY_W-1:0] KEY_BELOW_MSB = 64'h7FFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst;

  pst_req_if req_ch ();
  pst_rsp_if rsp_ch ();

  int mismatches;
  int outstanding;

  permuted_sorted_node_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  pst_node_table_check u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // traffic shaping shared by the two sides
  int  sent;
  int  idle_odds;            // 1 in idle_odds requests is preceded by a gap, 0 means none
  bit  rsp_throttle = 1'b1;  // random ready bursts on the response side
  bit  hold_ready_req;       // asks the response side for one long hold-off

  // key pool: keys that the random part inserts, upserts and later removes
  logic [KEY_W-1:0] key_pool [$];

  // one request: optional idle burst first, then hold valid until taken
  task automatic send_request(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind  <= op;
    req_ch.key   <= k;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    // long hold-off once, while the sender keeps pushing
    if (sent == HOLD_AT) hold_ready_req = 1'b1;
    if (sent >= ITEMS - QUIET_TAIL) begin
      idle_odds = 0;
      rsp_throttle = 1'b0;
    end
  endtask

  // stop offering and wait until every predicted response has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // response side: ready bursts, plus the single long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ready_req) begin
        hold_ready_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (rsp_throttle && $urandom_range(0, 7) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog: any handshake restarts the count
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request or response moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [KIND_W-1:0] op;
    logic [KEY_W-1:0]  k;
    logic [KEY_W-1:0]  cluster_base;
    int                phase_pick;
    int                round;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.kind  <= KIND_LOOKUP;
    req_ch.key   <= '0;
    req_ch.value <= '0;
    sent = 0;
    round = 0;
    idle_odds = 4;
    hold_ready_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // empty node: lookup and remove both miss at rank 0
    send_request(KIND_LOOKUP, 64'd5, rand_word());
    send_request(KIND_REMOVE, 64'd5, rand_word());
    // key extremes, stored out of sorted order
    send_request(KIND_INSERT, KEY_TOP, '1);
    send_request(KIND_INSERT, '0, '0);
    send_request(KIND_INSERT, KEY_MSB, rand_word());
    // insert of a present key is rejected
    send_request(KIND_INSERT, '0, rand_word());
    // upsert of a present key replaces the value in place
    send_request(KIND_UPSERT, '0, 64'hA5A5_5A5A_F00F_0FF0);
    send_request(KIND_LOOKUP, '0, rand_word());
    // miss between two stored keys, across the sign bit
    send_request(KIND_LOOKUP, KEY_BELOW_MSB, rand_word());
    // removing the lowest key compacts the later physical slot
    send_request(KIND_REMOVE, '0, rand_word());
    // upsert of an absent key inserts
    send_request(KIND_UPSERT, KEY_BELOW_MSB, rand_word());
    // fill to capacity with small keys
    for (int i = 1; i <= 13; i++) send_request(KIND_INSERT, KEY_W'(i), rand_word());
    // full node: insert and upsert-insert flag it, upsert of a present key still works
    send_request(KIND_INSERT, 64'h100, rand_word());
    send_request(KIND_UPSERT, 64'h200, rand_word());
    send_request(KIND_UPSERT, 64'd7, rand_word());
    send_request(KIND_LOOKUP, KEY_TOP, rand_word());
    wait_drained();

    // first pool starts from the keys already held
    key_pool.push_back(KEY_TOP);
    key_pool.push_back(KEY_MSB);
    key_pool.push_back(KEY_BELOW_MSB);
    for (int i = 0; i <= 13; i++) key_pool.push_back(KEY_W'(i));
    while (key_pool.size() < POOL_SIZE) key_pool.push_back(rand_word());

    // ---- random part: rounds of fill, churn and drain over a key pool ----
    while (sent < ITEMS) begin
      if (round != 0) begin
        // fresh pool: random keys, keys sharing upper bits, and extremes
        key_pool.delete();
        cluster_base = rand_word();
        for (int i = 0; i < POOL_SIZE; i++) begin
          case ($urandom_range(0, 3))
            0: k = rand_word();
            1, 2: k = {cluster_base[KEY_W-1:8], 8'($urandom)};
            default: begin
              case ($urandom_range(0, 3))
                0: k = '0;
                1: k = KEY_TOP;
                2: k = KEY_MSB;
                default: k = KEY_BELOW_MSB;
              endcase
            end
          endcase
          key_pool.push_back(k);
        end
      end
      if (sent < ITEMS - QUIET_TAIL) begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 3;
          default: idle_odds = 8;
        endcase
      end

      for (int n = 0; n < ROUND_LEN; n++) begin
        phase_pick = $urandom_range(0, 99);
        if (n < ROUND_LEN * 3 / 8) begin
          // fill: mostly inserts and upserts, so the node reaches full
          if (phase_pick < 45) op = KIND_INSERT;
          else if (phase_pick < 70) op = KIND_UPSERT;
          else if (phase_pick < 90) op = KIND_LOOKUP;
          else op = KIND_REMOVE;
        end else if (n < ROUND_LEN * 3 / 4) begin
          op = KIND_W'($urandom_range(0, 3));
        end else begin
          // drain: mostly removes
          if (phase_pick < 50) op = KIND_REMOVE;
          else if (phase_pick < 80) op = KIND_LOOKUP;
          else if (phase_pick < 90) op = KIND_INSERT;
          else op = KIND_UPSERT;
        end
        if ($urandom_range(0, 99) < 85) begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else begin
          // off-pool key: neighbor of a pool key or anything at all
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
          case ($urandom_range(0, 2))
            0: k = k + 1;
            1: k = k - 1;
            default: k = rand_word();
          endcase
          // off-pool keys never get stored, so each round can empty the node
          if (op == KIND_INSERT || op == KIND_UPSERT)
            op = ($urandom_range(0, 1) != 0) ? KIND_LOOKUP : KIND_REMOVE;
        end
        send_request(op, k, rand_word());
      end

      // empty the node: remove every pool key, misses included
      foreach (key_pool[i]) send_request(KIND_REMOVE, key_pool[i], rand_word());
      // pause for every response, except in the gap-free tail
      if (sent < ITEMS - QUIET_TAIL) wait_drained();
      round++;
    end

    // collect the last responses, then let any stray one show up before the verdict
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: permuted_sorted_node_table.f
+incdir+rtl
rtl/pst_pkg.sv
rtl/pst_ifs.sv
rtl/pst_ram.sv
rtl/pst_cmp.sv
rtl/permuted_sorted_node_table.sv
tb/sv/pst_node_table_check.sv
tb/sv/tb_permuted_sorted_node_table.sv
